// ===== design/ellipsoid_to_stiffness_map_unit_macros.svh =====
// ellipsoid_to_stiffness_map_unit_macros.svh
// assertion macros for the ellipsoid to stiffness map checker
// no dependencies
`ifndef ELLIPSOID_TO_STIFFNESS_MAP_UNIT_MACROS_SVH
`define ELLIPSOID_TO_STIFFNESS_MAP_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ESM_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("esm check failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ESM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("esm check failed: next-cycle implication");

`endif

// ===== design/esm_pkg.sv =====
// esm_pkg.sv
// shared types and constants of the ellipsoid to stiffness map
// no dependencies
package esm_pkg;

    localparam int NUM_LANES   = 3;
    localparam int AXIS_W      = 32;
    localparam int MAG_W       = 32;
    localparam int STIFF_W     = 16;
    localparam int THR_W       = 17;
    localparam int FACTOR_W    = 17;
    localparam int OUT_W       = 24;
    localparam int S_DATA_W    = NUM_LANES * AXIS_W;
    localparam int M_DATA_W    = 2 * NUM_LANES * OUT_W;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // pipeline depth outside the divider
    localparam int FRONT_STAGES      = 2;
    localparam int LANE_EXTRA_STAGES = 7;

    // register reset values
    localparam logic [STIFF_W-1:0] RST_MAX_TRANS = 16'd5000;
    localparam logic [STIFF_W-1:0] RST_MAX_ROT   = 16'd300;
    localparam logic [THR_W-1:0]   RST_LOW_THR   = 17'd6554;
    localparam logic [THR_W-1:0]   RST_HIGH_THR  = 17'd58982;

    // factor map constants
    localparam logic [FACTOR_W-1:0] FACTOR_ONE   = 17'd65536;
    localparam logic [FACTOR_W-1:0] FACTOR_FLOOR = 17'd131;
    localparam logic [FACTOR_W-1:0] FACTOR_ZERO  = 17'd0;
    localparam logic [16:0]         SLOPE_K      = 17'd124750;
    localparam logic [16:0]         BASE_K       = 17'd112475;
    // 112475 * 65536 + 50000, offset for round-half-up
    localparam logic [33:0]         LIN_C0       = 34'd7371211600;
    localparam logic [16:0]         LIN_DEN      = 17'd100000;
    // floor(2^34 / 100000)
    localparam logic [17:0]         RECIP_M      = 18'd171798;
    localparam int                  RECIP_SHIFT  = 34;
    localparam logic [OUT_W-1:0]    OUT_MAX      = 24'd16776960;

    typedef enum logic [1:0] {
        REG_MAX_TRANS,
        REG_MAX_ROT,
        REG_LOW_THR,
        REG_HIGH_THR
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_ONE,
        MODE_FLOOR,
        MODE_LINEAR,
        MODE_ZERO
    } fmode_t;

    typedef struct packed {
        logic [STIFF_W-1:0] max_trans;
        logic [STIFF_W-1:0] max_rot;
        logic [THR_W-1:0]   low_thr;
        logic [THR_W-1:0]   high_thr;
    } cfg_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] biggest;
        logic             all_zero;
    } lane_in_t;

    typedef struct packed {
        logic [OUT_W-1:0] trans;
        logic [OUT_W-1:0] rot;
    } stiff_t;

endpackage

// ===== design/esm_front.sv =====
// esm_front.sv
// axis magnitudes and largest magnitude, two register stages
// depends on esm_pkg
module esm_front (
    input  logic                                    aclk,
    input  logic                                    en,
    input  logic [esm_pkg::S_DATA_W-1:0]            axes,
    output esm_pkg::lane_in_t                       lane_in [esm_pkg::NUM_LANES]
);
    import esm_pkg::*;

    logic [MAG_W-1:0] mag_reg  [NUM_LANES];
    logic [MAG_W-1:0] mag2_reg [NUM_LANES];
    logic [MAG_W-1:0] big_reg;
    logic             zero_reg;
    logic [MAG_W-1:0] big_xy;
    logic [MAG_W-1:0] big_next;

    // magnitude of each axis, -2^31 maps to 2^31
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                mag_reg[i] <= axes[i*AXIS_W + AXIS_W-1]
                            ? (~axes[i*AXIS_W +: AXIS_W]) + 32'd1
                            : axes[i*AXIS_W +: AXIS_W];
            end
        end
    end

    // largest of the three
    always_comb begin
        big_xy   = (mag_reg[1] > mag_reg[0]) ? mag_reg[1] : mag_reg[0];
        big_next = (mag_reg[2] > big_xy) ? mag_reg[2] : big_xy;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag2_reg <= mag_reg;
            big_reg  <= big_next;
            zero_reg <= (big_next == '0);
        end
    end

    // fan out to the lanes
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            lane_in[i].mag      = mag2_reg[i];
            lane_in[i].biggest  = big_reg;
            lane_in[i].all_zero = zero_reg;
        end
    end

endmodule

// ===== design/esm_lane.sv =====
// esm_lane.sv
// one axis lane: pipelined ratio divider, factor map and stiffness scaling
// depends on esm_pkg
module esm_lane #(
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              en,
    input  esm_pkg::cfg_t     cfg,
    input  esm_pkg::lane_in_t lane_in,
    output esm_pkg::stiff_t   result
);
    import esm_pkg::*;

    localparam int RW = RATIO_FRAC_BITS + 1;
    localparam int PW = RW + 17;

    // divider stages, one quotient bit each
    logic [32:0]      div_r_reg [RW];
    logic [RW-1:0]    div_q_reg [RW];
    logic [MAG_W-1:0] div_b_reg [RW];
    logic             div_z_reg [RW];

    for (genvar k = 0; k < RW; k++) begin : g_div
        logic [32:0]      rin;
        logic [RW-1:0]    qin;
        logic [MAG_W-1:0] bin;
        logic             zin;
        logic             ge;

        if (k == 0) begin : g_head
            assign rin = {1'b0, lane_in.mag};
            assign qin = '0;
            assign bin = lane_in.biggest;
            assign zin = lane_in.all_zero;
        end else begin : g_body
            assign rin = {div_r_reg[k-1][31:0], 1'b0};
            assign qin = div_q_reg[k-1];
            assign bin = div_b_reg[k-1];
            assign zin = div_z_reg[k-1];
        end

        assign ge = (rin >= {1'b0, bin});

        always_ff @(posedge aclk) begin
            if (en) begin
                div_r_reg[k] <= ge ? (rin - {1'b0, bin}) : rin;
                div_q_reg[k] <= {qin[RW-2:0], ge};
                div_b_reg[k] <= bin;
                div_z_reg[k] <= zin;
            end
        end
    end

    logic [RW-1:0] ratio;
    assign ratio = div_q_reg[RW-1];

    // stage 1: threshold tests and slope product
    fmode_t        mode1_reg;
    logic [PW-1:0] p1_reg;
    fmode_t        mode1_next;

    always_comb begin
        if (div_z_reg[RW-1]) begin
            mode1_next = MODE_ONE;
        end else if ({ratio, 16'b0} < {cfg.low_thr, {RATIO_FRAC_BITS{1'b0}}}) begin
            mode1_next = MODE_ONE;
        end else if ({ratio, 16'b0} > {cfg.high_thr, {RATIO_FRAC_BITS{1'b0}}}) begin
            mode1_next = MODE_FLOOR;
        end else begin
            mode1_next = MODE_LINEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode1_reg <= mode1_next;
            p1_reg    <= PW'(SLOPE_K) * PW'(ratio);
        end
    end

    // stage 2: numerator of the linear part, negative clamp
    logic [33:0] pc;
    fmode_t      mode2_reg;
    logic [32:0] t2_reg;

    if (RATIO_FRAC_BITS > 16) begin : g_pc_down
        localparam int SH = RATIO_FRAC_BITS - 16;
        assign pc = 34'(p1_reg >> SH) + 34'(|p1_reg[SH-1:0]);
    end else begin : g_pc_up
        assign pc = 34'(p1_reg) << (16 - RATIO_FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode2_reg <= (mode1_reg == MODE_LINEAR
                          && p1_reg >= PW'({BASE_K, {RATIO_FRAC_BITS{1'b0}}}))
                       ? MODE_ZERO : mode1_reg;
            t2_reg    <= 33'(LIN_C0 - pc);
        end
    end

    // stage 3: reciprocal product for the divide by 100000
    fmode_t      mode3_reg;
    logic [32:0] t3_reg;
    logic [50:0] q3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mode3_reg <= mode2_reg;
            t3_reg    <= t2_reg;
            q3_reg    <= 51'(t2_reg) * 51'(RECIP_M);
        end
    end

    // stage 4: quotient estimate times the divisor
    fmode_t              mode4_reg;
    logic [32:0]         t4_reg;
    logic [FACTOR_W-1:0] q4_reg;
    logic [33:0]         qd4_reg;
    logic [FACTOR_W-1:0] q_est;

    assign q_est = q3_reg[RECIP_SHIFT +: FACTOR_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            mode4_reg <= mode3_reg;
            t4_reg    <= t3_reg;
            q4_reg    <= q_est;
            qd4_reg   <= 34'(q_est) * 34'(LIN_DEN);
        end
    end

    // stage 5: correction by one and factor selection
    logic [33:0]         rem;
    logic [FACTOR_W-1:0] fac_next;
    logic [FACTOR_W-1:0] fac5_reg;

    always_comb begin
        rem = {1'b0, t4_reg} - qd4_reg;
        case (mode4_reg)
            MODE_ONE:    fac_next = FACTOR_ONE;
            MODE_FLOOR:  fac_next = FACTOR_FLOOR;
            MODE_ZERO:   fac_next = FACTOR_ZERO;
            MODE_LINEAR: fac_next = q4_reg + FACTOR_W'(rem >= 34'(LIN_DEN));
            default:     fac_next = FACTOR_ZERO;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fac5_reg <= fac_next;
        end
    end

    // stage 6: stiffness products
    logic [32:0] pt6_reg;
    logic [32:0] pr6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pt6_reg <= 33'(cfg.max_trans) * 33'(fac5_reg);
            pr6_reg <= 33'(cfg.max_rot) * 33'(fac5_reg);
        end
    end

    // stage 7: round to 1/256 and saturate
    logic [33:0]      st_sum;
    logic [33:0]      sr_sum;
    logic [25:0]      st_sh;
    logic [25:0]      sr_sh;
    logic [OUT_W-1:0] trans_reg;
    logic [OUT_W-1:0] rot_reg;

    always_comb begin
        st_sum = {1'b0, pt6_reg} + 34'd128;
        sr_sum = {1'b0, pr6_reg} + 34'd128;
        st_sh  = st_sum[33:8];
        sr_sh  = sr_sum[33:8];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            trans_reg <= (st_sh > 26'(OUT_MAX)) ? OUT_MAX : st_sh[OUT_W-1:0];
            rot_reg   <= (sr_sh > 26'(OUT_MAX)) ? OUT_MAX : sr_sh[OUT_W-1:0];
        end
    end

    assign result.trans = trans_reg;
    assign result.rot   = rot_reg;

endmodule

// ===== design/esm_out.sv =====
// esm_out.sv
// merges the lane results into one transaction, output register plus skid entry
// depends on esm_pkg
module esm_out (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  esm_pkg::stiff_t              lane_res [esm_pkg::NUM_LANES],
    output logic                         room,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // trans_stiff_x, trans_stiff_y, trans_stiff_z, rot_stiff_x, rot_stiff_y, rot_stiff_z
    output logic [esm_pkg::M_DATA_W-1:0] m_tdata
);
    import esm_pkg::*;

    logic [M_DATA_W-1:0] data_in;
    logic [M_DATA_W-1:0] main_data_reg, main_data_next;
    logic [M_DATA_W-1:0] skid_data_reg, skid_data_next;
    logic                main_valid_reg, main_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    logic                pop;

    // pack translational fields first, then rotational
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            data_in[i*OUT_W +: OUT_W]               = lane_res[i].trans;
            data_in[(NUM_LANES+i)*OUT_W +: OUT_W]   = lane_res[i].rot;
        end
    end

    // two-entry buffer control
    always_comb begin
        pop             = main_valid_reg && m_tready;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (main_valid_reg && !pop) begin
            if (push) begin
                skid_data_next  = data_in;
                skid_valid_next = 1'b1;
            end
        end else begin
            main_valid_next = push;
            if (push) begin
                main_data_next = data_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign room     = !skid_valid_reg;
    assign m_tvalid = main_valid_reg;
    assign m_tdata  = main_data_reg;

endmodule

// ===== design/ellipsoid_to_stiffness_map_unit.sv =====
// ellipsoid_to_stiffness_map_unit.sv
// top level: config registers, front stage, three axis lanes, output merge
// depends on esm_pkg, esm_front, esm_lane, esm_out
//
//  channel   direction  transaction
//  s_*       in         axis_x, axis_y, axis_z (signed Q16.16)
//  m_*       out        trans_stiff_x/y/z, rot_stiff_x/y/z (1/256 units)
//  APB       in/out     four config registers at byte address 4*i
//
// one item per cycle sustained while the output is not stalled; the divider pipeline
// resolves one ratio bit per stage
// reset is synchronous: clears the pipeline valids and output buffer, loads
// register defaults; there is no clearing pass
// on a stall the output register and one skid entry fill, and s_tready drops
// right after the edge that loads the skid entry; the whole pipeline then holds
module ellipsoid_to_stiffness_map_unit #(
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // axis_x, axis_y, axis_z
    input  logic [esm_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // trans_stiff_x, trans_stiff_y, trans_stiff_z, rot_stiff_x, rot_stiff_y, rot_stiff_z
    output logic [esm_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [esm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [esm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [esm_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import esm_pkg::*;

    localparam int DEPTH = FRONT_STAGES + RATIO_FRAC_BITS + 1 + LANE_EXTRA_STAGES;

    cfg_t     cfg_reg;
    reg_idx_t reg_sel;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // config register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_trans <= RST_MAX_TRANS;
            cfg_reg.max_rot   <= RST_MAX_ROT;
            cfg_reg.low_thr   <= RST_LOW_THR;
            cfg_reg.high_thr  <= RST_HIGH_THR;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_MAX_TRANS: cfg_reg.max_trans <= pwdata[STIFF_W-1:0];
                REG_MAX_ROT:   cfg_reg.max_rot   <= pwdata[STIFF_W-1:0];
                REG_LOW_THR:   cfg_reg.low_thr   <= pwdata[THR_W-1:0];
                REG_HIGH_THR:  cfg_reg.high_thr  <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // config read back
    always_comb begin
        case (reg_sel)
            REG_MAX_TRANS: prdata = APB_DATA_W'(cfg_reg.max_trans);
            REG_MAX_ROT:   prdata = APB_DATA_W'(cfg_reg.max_rot);
            REG_LOW_THR:   prdata = APB_DATA_W'(cfg_reg.low_thr);
            REG_HIGH_THR:  prdata = APB_DATA_W'(cfg_reg.high_thr);
            default:       prdata = '0;
        endcase
    end

    // pipeline advance and valid tracking
    logic             en;
    logic             room;
    logic [DEPTH-1:0] valid_reg;

    assign en       = room;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[DEPTH-2:0], s_tvalid};
        end
    end

    // datapath
    lane_in_t lane_in  [NUM_LANES];
    stiff_t   lane_res [NUM_LANES];

    esm_front u_front (
        .aclk    (aclk),
        .en      (en),
        .axes    (s_tdata),
        .lane_in (lane_in)
    );

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        esm_lane #(
            .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
        ) u_lane (
            .aclk    (aclk),
            .en      (en),
            .cfg     (cfg_reg),
            .lane_in (lane_in[i]),
            .result  (lane_res[i])
        );
    end

    esm_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (valid_reg[DEPTH-1] && en),
        .lane_res (lane_res),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== design/esm_checker.sv =====
// esm_checker.sv
// port-level checks of the ellipsoid to stiffness map, bound to the top level
// depends on esm_pkg and ellipsoid_to_stiffness_map_unit_macros.svh
`include "ellipsoid_to_stiffness_map_unit_macros.svh"

module esm_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [esm_pkg::M_DATA_W-1:0] m_tdata
);
    import esm_pkg::*;

    // a stalled result transaction holds
    `ESM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // input back-pressure only while a result is waiting
    `ESM_ASSERT_SAME(a_bp_needs_out, aclk, aresetn, !s_tready, m_tvalid)

    // input side closes only after an output stall
    `ESM_ASSERT_SAME(a_bp_cause, aclk, aresetn, $fell(s_tready), $past(m_tvalid && !m_tready))

    // nothing is offered right after reset
    `ESM_ASSERT_SAME(a_reset_empty, aclk, 1'b1, $past(!aresetn), !m_tvalid && s_tready)

endmodule

bind ellipsoid_to_stiffness_map_unit esm_checker u_esm_checker (.*);
